@@ sv/rs485_pd_pkg.sv @@
// Shared types, codes and the byte-wide CRC-16/MODBUS update for the
// RS-485 packet deframer. No dependencies.
`timescale 1ns / 1ps

package rs485_pd_pkg;

   // Receive sequencer states
   typedef enum logic [2:0] {
      ST_HUNT,
      ST_HEADER,
      ST_PAYLOAD,
      ST_CRC_LO,
      ST_CRC_HI
   } st_type;

   // Result kinds carried on rsp_tuser
   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_GOOD      = 3'd1,
      KIND_BAD_CRC   = 3'd2,
      KIND_NOT_ME    = 3'd3,
      KIND_BAD_CMD   = 3'd4,
      KIND_NO_HANDLR = 3'd5,
      KIND_TOO_LONG  = 3'd6
   } kind_type;

   // Header byte positions after the preamble
   typedef enum logic [2:0] {
      HDR_DEST   = 3'd0,
      HDR_SOURCE = 3'd1,
      HDR_SEQ_HI = 3'd2,
      HDR_SEQ_LO = 3'd3,
      HDR_CMD    = 3'd4,
      HDR_LEN_HI = 3'd5,
      HDR_LEN_LO = 3'd6
   } hdr_type;

   // Configuration register indexes
   localparam logic CSR_OWN_ADDRESS  = 1'b0;
   localparam logic CSR_HANDLER_MASK = 1'b1;

   localparam logic [7:0]  SYNC_BYTE = 8'hA5;
   localparam logic [7:0]  ALL_NODES = 8'hFF;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   // One byte of reflected CRC-16/MODBUS: eight shift/xor steps
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ sv/rs485_packet_deframer_unit.sv @@
// RS-485 packet deframer: preamble hunt, header capture, drop checks,
// payload streaming and CRC-16/MODBUS verdict. Uses rs485_pd_pkg.
`timescale 1ns / 1ps

// Takes one received byte per beat on req_ and sustains one byte per clock
// while rsp_ is ready: each byte is held in an input register, the whole
// per-byte step (header capture, drop checks, one byte of CRC-16/MODBUS
// through the eight-step xor network) is combinational from that register,
// and any result lands in the registered rsp_ output. While a result waits
// on rsp_tready, the next byte is held in the input register and req_tready
// stays low until the result is taken. The block hunts for PREAMBLE_LEN
// bytes of 0xA5 (a wrong byte restarts the hunt silently), collects
// destination, source, sequence (big-endian), command and length
// (big-endian), then either drops the packet with a status beat (not
// addressed, bad command, no handler, too long, checked in that order) or
// emits one beat per payload byte, and closes with a good or bad-CRC beat
// after the two CRC bytes (low byte first). own_address and handler_mask
// are written on the csr_ port (index 0 and 1); the user must write them
// only while the block is idle, which the block itself does not enforce;
// the drop checks use the values held when the last header byte arrives.
module rs485_packet_deframer_unit #(
   parameter int NUM_COMMANDS = 16,
   parameter int MAX_PAYLOAD  = 256,
   parameter int PREAMBLE_LEN = 8
) (
   input  logic        clock,
   input  logic        reset,
   // receive byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] payload_byte, [15:8] source,
                                    // [31:16] sequence_res, [39:32] command,
                                    // [55:40] payload_length, [56] broadcast,
                                    // [63:57] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import rs485_pd_pkg::*;

   localparam int PRE_W = (PREAMBLE_LEN > 1) ? $clog2(PREAMBLE_LEN) : 1;
   localparam int PAY_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PREAMBLE_LEN - 1);

   // configuration
   logic [6:0]  own_address_ff;
   logic [15:0] handler_mask_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        advance;

   // sequencer state
   st_type            state_ff, state_in;
   logic [PRE_W-1:0]  pre_cnt_ff, pre_cnt_in;
   hdr_type           hdr_cnt_ff, hdr_cnt_in;
   logic [PAY_W-1:0]  pay_cnt_ff, pay_cnt_in;
   logic [15:0]       crc_ff, crc_in;

   // header and CRC capture
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  source_ff, source_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  crc_first_ff, crc_first_in;

   // per-byte decisions
   logic [15:0] crc_byte;
   kind_type    check_kind;
   logic        pay_last;
   logic        emit;
   kind_type    emit_kind;
   logic [7:0]  emit_byte;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [7:0]  rsp_source_ff, rsp_source_in;
   logic [15:0] rsp_seq_ff, rsp_seq_in;
   logic [7:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [15:0] rsp_len_ff, rsp_len_in;
   logic        rsp_bcast_ff, rsp_bcast_in;

   // configuration port: always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff  <= '0;
         handler_mask_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OWN_ADDRESS:  own_address_ff  <= csr_data[6:0];
            CSR_HANDLER_MASK: handler_mask_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   // input register handshake: step a byte when the result slot is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign crc_byte = crc16_byte(crc_ff, in_byte_ff);
   assign pay_last = ({{(17 - PAY_W){1'b0}}, pay_cnt_ff} + 17'd1) == {1'b0, len_ff};

   // header field capture
   always_comb begin
      dest_in      = dest_ff;
      source_in    = source_ff;
      seq_in       = seq_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      crc_first_in = crc_first_ff;
      if (advance) begin
         if (state_ff == ST_HEADER) begin
            case (hdr_cnt_ff)
               HDR_DEST:   dest_in      = in_byte_ff;
               HDR_SOURCE: source_in    = in_byte_ff;
               HDR_SEQ_HI: seq_in[15:8] = in_byte_ff;
               HDR_SEQ_LO: seq_in[7:0]  = in_byte_ff;
               HDR_CMD:    cmd_in       = in_byte_ff;
               HDR_LEN_HI: len_in[15:8] = in_byte_ff;
               HDR_LEN_LO: len_in[7:0]  = in_byte_ff;
               default:    ;
            endcase
         end else if (state_ff == ST_CRC_LO) begin
            crc_first_in = in_byte_ff;
         end
      end
   end

   // drop checks on the completed header, in priority order
   always_comb begin
      check_kind = KIND_GOOD;
      if (dest_ff != {1'b0, own_address_ff} && dest_ff != ALL_NODES) begin
         check_kind = KIND_NOT_ME;
      end else if ({1'b0, cmd_ff} >= 9'(NUM_COMMANDS)) begin
         check_kind = KIND_BAD_CMD;
      end else if (!handler_mask_ff[cmd_ff[3:0]]) begin
         check_kind = KIND_NO_HANDLR;
      end else if ({1'b0, len_in} > 17'(MAX_PAYLOAD)) begin
         check_kind = KIND_TOO_LONG;
      end
   end

   // next state, counters and running CRC
   always_comb begin
      state_in   = state_ff;
      pre_cnt_in = pre_cnt_ff;
      hdr_cnt_in = hdr_cnt_ff;
      pay_cnt_in = pay_cnt_ff;
      crc_in     = crc_ff;
      if (advance) begin
         case (state_ff)
            ST_HUNT: begin
               crc_in = CRC_INIT;
               if (in_byte_ff != SYNC_BYTE) begin
                  pre_cnt_in = '0;
               end else if (pre_cnt_ff == PRE_LAST) begin
                  pre_cnt_in = '0;
                  hdr_cnt_in = HDR_DEST;
                  state_in   = ST_HEADER;
               end else begin
                  pre_cnt_in = pre_cnt_ff + PRE_W'(1);
               end
            end
            ST_HEADER: begin
               crc_in = crc_byte;
               if (hdr_cnt_ff == HDR_LEN_LO) begin
                  pay_cnt_in = '0;
                  if (check_kind != KIND_GOOD) begin
                     crc_in   = CRC_INIT;
                     state_in = ST_HUNT;
                  end else if (len_in == 16'd0) begin
                     state_in = ST_CRC_LO;
                  end else begin
                     state_in = ST_PAYLOAD;
                  end
               end else begin
                  hdr_cnt_in = hdr_type'(hdr_cnt_ff + 3'd1);
               end
            end
            ST_PAYLOAD: begin
               crc_in     = crc_byte;
               pay_cnt_in = pay_cnt_ff + PAY_W'(1);
               if (pay_last) begin
                  state_in = ST_CRC_LO;
               end
            end
            ST_CRC_LO: begin
               state_in = ST_CRC_HI;
            end
            ST_CRC_HI: begin
               crc_in   = CRC_INIT;
               state_in = ST_HUNT;
            end
            default: begin
               crc_in   = CRC_INIT;
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   // result decision for the byte in the input register
   always_comb begin
      emit      = 1'b0;
      emit_kind = KIND_PAYLOAD;
      emit_byte = 8'h00;
      case (state_ff)
         ST_HEADER: begin
            if (hdr_cnt_ff == HDR_LEN_LO && check_kind != KIND_GOOD) begin
               emit      = 1'b1;
               emit_kind = check_kind;
            end
         end
         ST_PAYLOAD: begin
            emit      = 1'b1;
            emit_kind = KIND_PAYLOAD;
            emit_byte = in_byte_ff;
         end
         ST_CRC_HI: begin
            emit = 1'b1;
            if (crc_first_ff == crc_ff[7:0] && in_byte_ff == crc_ff[15:8]) begin
               emit_kind = KIND_GOOD;
            end else begin
               emit_kind = KIND_BAD_CRC;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_source_in = rsp_source_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_bcast_in  = rsp_bcast_ff;
      if (advance) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_kind_in   = emit_kind;
            rsp_byte_in   = emit_byte;
            rsp_source_in = source_in;
            rsp_seq_in    = seq_in;
            rsp_cmd_in    = cmd_in;
            rsp_len_in    = len_in;
            rsp_bcast_in  = (dest_in == ALL_NODES);
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_HUNT;
         pre_cnt_ff   <= '0;
         hdr_cnt_ff   <= HDR_DEST;
         pay_cnt_ff   <= '0;
         crc_ff       <= CRC_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         pre_cnt_ff   <= pre_cnt_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         pay_cnt_ff   <= pay_cnt_in;
         crc_ff       <= crc_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      dest_ff       <= dest_in;
      source_ff     <= source_in;
      seq_ff        <= seq_in;
      cmd_ff        <= cmd_in;
      len_ff        <= len_in;
      crc_first_ff  <= crc_first_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_source_ff <= rsp_source_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_bcast_ff  <= rsp_bcast_in;
   end

   // ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'd0, rsp_bcast_ff, rsp_len_ff, rsp_cmd_ff, rsp_seq_ff,
                        rsp_source_ff, rsp_byte_ff};

   // a preamble byte never produces a beat
   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff == ST_HUNT) |=> !rsp_valid_ff)
      else $error("result produced during preamble hunt");

   // payload streaming only for lengths that passed the size check
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAYLOAD) |->
         ({1'b0, len_ff} <= 17'(MAX_PAYLOAD) && {{(17 - PAY_W){1'b0}}, pay_cnt_ff}
          < {1'b0, len_ff}))
      else $error("payload counter beyond length");

   // a verdict closes the frame and restarts the CRC
   a_verdict_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff == ST_CRC_HI) |=>
         (state_ff == ST_HUNT && crc_ff == CRC_INIT && rsp_valid_ff))
      else $error("frame not closed after CRC bytes");

   // a payload beat carries a payload kind only out of the payload state
   a_payload_kind: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff == ST_PAYLOAD) |=> (rsp_kind_ff == KIND_PAYLOAD))
      else $error("payload byte with wrong kind");

endmodule
